@@ design/qce_pkg.sv @@
package qce_pkg;

    // Default sizes of the pair table and of the stored moduli.
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int PRIME_BITS_DEF  = 32;

    // Fixed field widths of the two channels.
    localparam int IN_W       = 32;
    localparam int SLOT_FLD_W = 6;
    localparam int A_W        = 48;
    localparam int B_W        = 40;
    localparam int CNT_W      = 7;
    localparam int STEP_W     = 6;

    // Reset value of the pairs-in-use register.
    localparam logic [CNT_W-1:0] PAIRS_RESET = 7'd32;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Operation of the shared modular adder.
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    cin;
    } alu_ctl_t;

endpackage

@@ design/qce_alu.sv @@
module qce_alu
    import qce_pkg::*;
#(
    parameter int PRIME_BITS = PRIME_BITS_DEF
)
(
    input  alu_ctl_t              ctl,
    input  logic [PRIME_BITS-1:0] x,
    input  logic [PRIME_BITS-1:0] y,
    input  logic [PRIME_BITS-1:0] m,
    output logic [PRIME_BITS-1:0] res,
    output logic                  flag
);

    logic [PRIME_BITS:0] sum;
    logic [PRIME_BITS:0] sum_red;
    logic                sum_ge;
    logic [PRIME_BITS:0] diff;
    logic [PRIME_BITS:0] diff_fix;

    // Modular add with carry-in: inputs below m, so one subtraction of m suffices.
    assign sum     = {1'b0, x} + {1'b0, y} + (PRIME_BITS + 1)'(ctl.cin);
    assign sum_ge  = (sum >= {1'b0, m});
    assign sum_red = sum - {1'b0, m};

    // Modular subtract: a borrow is repaired by adding m back.
    assign diff     = {1'b0, x} - {1'b0, y};
    assign diff_fix = diff + {1'b0, m};

    always_comb
    begin
        if (ctl.op == ALU_SUB)
        begin
            res  = diff[PRIME_BITS] ? diff_fix[PRIME_BITS-1:0] : diff[PRIME_BITS-1:0];
            flag = diff[PRIME_BITS];
        end
        else
        begin
            res  = sum_ge ? sum_red[PRIME_BITS-1:0] : sum[PRIME_BITS-1:0];
            flag = sum_ge;
        end
    end

endmodule

@@ design/quadratic_character_engine.sv @@
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid / in_stall  req_type, slot, prime, root, a_value, b_value
// output    out        out_valid / out_stall pair_index, char_bit, last
// config    in         cfg_we               cfg_wdata (pairs in use)
//
// A load beat writes its slot, if within the table, in the cycle it is taken. A query walks
// each pair in turn: it reduces |a| modulo the prime, negates it for a negative a, reduces the
// root, forms root*b mod q, takes the difference and runs the binary Jacobi loop, all through
// the one shared modular adder. An even or zero modulus goes from the check straight to emit.
// Input is stalled while a query runs; the walk pauses while the output register is full.
// Reset clears control state only; table entries are undefined until loaded.
module quadratic_character_engine
    import qce_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PRIME_BITS  = PRIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [SLOT_FLD_W-1:0] slot,
    input  logic [IN_W-1:0]       prime,
    input  logic [IN_W-1:0]       root,
    input  logic signed [A_W-1:0] a_value,
    input  logic [B_W-1:0]        b_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SLOT_FLD_W-1:0] pair_index,
    output logic                  char_bit,
    output logic                  last
);

    localparam int P      = PRIME_BITS;
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_READ  = 10'b00_0000_0010,
        ST_CHECK = 10'b00_0000_0100,
        ST_REDA  = 10'b00_0000_1000,
        ST_NEGA  = 10'b00_0001_0000,
        ST_REDS  = 10'b00_0010_0000,
        ST_MUL   = 10'b00_0100_0000,
        ST_DIFF  = 10'b00_1000_0000,
        ST_JAC   = 10'b01_0000_0000,
        ST_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pairs_reg;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic              phase_reg;
    logic              neg_reg;
    logic [A_W-1:0]    mag_q_reg, mag_sh_reg;
    logic [B_W-1:0]    b_q_reg, b_sh_reg;
    logic [P-1:0]      q_reg, s_sh_reg, acc_reg, am_reg, sm_reg, x_reg, n_reg;
    logic              t_reg;
    logic              bit_reg;
    logic              out_valid_reg;
    logic [SLOT_FLD_W-1:0] pair_index_reg;
    logic              char_bit_reg, last_reg;

    // Pair table with registered read.
    logic [P-1:0]      prime_mem [TABLE_DEPTH];
    logic [P-1:0]      root_mem  [TABLE_DEPTH];
    logic [P-1:0]      prime_rd_reg, root_rd_reg;

    logic              in_take, load_take, query_take;
    logic              out_take, out_free;
    logic [63:0]       prime_ext, root_ext;
    logic [A_W-1:0]    a_u, a_mag;
    logic [CNT_W-1:0]  lim_calc;
    logic              is_last_pair;

    alu_ctl_t          alu_ctl;
    logic [P-1:0]      alu_x, alu_y, alu_m, alu_res;
    logic              alu_flag;

    assign in_take    = in_valid && !in_stall;
    assign load_take  = in_take && (req_type == REQ_LOAD);
    assign query_take = in_take && (req_type == REQ_QUERY);
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_take   = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    assign prime_ext  = {32'd0, prime};
    assign root_ext   = {32'd0, root};
    assign a_u        = a_value;
    assign a_mag      = a_u[A_W-1] ? (~a_u + A_W'(1)) : a_u;
    assign lim_calc   = (pairs_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : pairs_reg;
    assign is_last_pair = ((idx_reg + CNT_W'(1)) == lim_reg);

    // Table write on a load beat within the table, read of the current pair.
    always_ff @(posedge clk)
    begin
        if (load_take && ({1'b0, slot} < CNT_W'(TABLE_DEPTH)))
        begin
            prime_mem[slot[SLOT_W-1:0]] <= prime_ext[P-1:0];
            root_mem[slot[SLOT_W-1:0]]  <= root_ext[P-1:0];
        end
        prime_rd_reg <= prime_mem[idx_reg[SLOT_W-1:0]];
        root_rd_reg  <= root_mem[idx_reg[SLOT_W-1:0]];
    end

    // Operand selection for the shared modular adder.
    always_comb
    begin
        alu_ctl = '{op: ALU_ADD, cin: 1'b0};
        alu_x   = acc_reg;
        alu_y   = acc_reg;
        alu_m   = q_reg;
        case (state_reg)
            ST_REDA:
            begin
                alu_ctl.cin = mag_sh_reg[A_W-1];
            end
            ST_REDS:
            begin
                alu_ctl.cin = s_sh_reg[P-1];
            end
            ST_MUL:
            begin
                if (phase_reg)
                begin
                    alu_y = b_sh_reg[B_W-1] ? sm_reg : '0;
                end
            end
            ST_NEGA:
            begin
                alu_ctl.op = ALU_SUB;
                alu_x      = '0;
            end
            ST_DIFF:
            begin
                alu_ctl.op = ALU_SUB;
                alu_x      = am_reg;
            end
            ST_JAC:
            begin
                alu_ctl.op = ALU_SUB;
                alu_x      = x_reg;
                alu_y      = n_reg;
                alu_m      = n_reg;
            end
            default:
            begin
                alu_ctl = '{op: ALU_ADD, cin: 1'b0};
            end
        endcase
    end

    qce_alu #(
        .PRIME_BITS (PRIME_BITS)
    ) u_alu (
        .ctl  (alu_ctl),
        .x    (alu_x),
        .y    (alu_y),
        .m    (alu_m),
        .res  (alu_res),
        .flag (alu_flag)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_take && (lim_calc != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = (prime_rd_reg[0] == 1'b0) ? ST_EMIT : ST_REDA;
            ST_REDA:
            begin
                if (step_reg == STEP_W'(A_W - 1))
                begin
                    state_next = ST_NEGA;
                end
            end
            ST_NEGA:  state_next = ST_REDS;
            ST_REDS:
            begin
                if (step_reg == STEP_W'(P - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (phase_reg && (step_reg == STEP_W'(B_W - 1)))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_JAC;
            ST_JAC:
            begin
                if (x_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last_pair ? ST_IDLE : ST_READ;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pairs_reg     <= PAIRS_RESET;
            lim_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                pairs_reg <= cfg_wdata;
            end
            if (query_take)
            begin
                lim_reg <= lim_calc;
                idx_reg <= '0;
            end
            else if ((state_reg == ST_EMIT) && out_free)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            // Step counter for the three bit-serial passes.
            if ((state_reg == ST_CHECK) || (state_reg == ST_NEGA) || (state_next != state_reg))
            begin
                step_reg  <= '0;
                phase_reg <= 1'b0;
            end
            else if ((state_reg == ST_REDA) || (state_reg == ST_REDS))
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else if (state_reg == ST_MUL)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end

            // Output register: a new character may replace one taken this cycle.
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (query_take)
        begin
            mag_q_reg <= a_mag;
            neg_reg   <= a_u[A_W-1];
            b_q_reg   <= b_value;
        end
        case (state_reg)
            ST_CHECK:
            begin
                q_reg      <= prime_rd_reg;
                s_sh_reg   <= root_rd_reg;
                mag_sh_reg <= mag_q_reg;
                b_sh_reg   <= b_q_reg;
                acc_reg    <= '0;
                bit_reg    <= 1'b1;
            end
            ST_REDA:
            begin
                acc_reg    <= alu_res;
                mag_sh_reg <= mag_sh_reg << 1;
            end
            ST_NEGA:
            begin
                am_reg  <= neg_reg ? alu_res : acc_reg;
                acc_reg <= '0;
            end
            ST_REDS:
            begin
                s_sh_reg <= s_sh_reg << 1;
                if (step_reg == STEP_W'(P - 1))
                begin
                    sm_reg  <= alu_res;
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= alu_res;
                end
            end
            ST_MUL:
            begin
                acc_reg <= alu_res;
                if (phase_reg)
                begin
                    b_sh_reg <= b_sh_reg << 1;
                end
            end
            ST_DIFF:
            begin
                x_reg <= alu_res;
                n_reg <= q_reg;
                t_reg <= 1'b0;
            end
            ST_JAC:
            begin
                if (x_reg == '0)
                begin
                    bit_reg <= !((n_reg == P'(1)) && !t_reg);
                end
                else if (!x_reg[0])
                begin
                    // Halving: the sign turns when n is 3 or 5 modulo 8.
                    x_reg <= x_reg >> 1;
                    if ((n_reg[2:0] == 3'd3) || (n_reg[2:0] == 3'd5))
                    begin
                        t_reg <= !t_reg;
                    end
                end
                else if (!alu_flag)
                begin
                    x_reg <= alu_res;
                end
                else
                begin
                    // Reciprocity swap when x is below n.
                    x_reg <= n_reg;
                    n_reg <= x_reg;
                    if ((x_reg[1:0] == 2'd3) && (n_reg[1:0] == 2'd3))
                    begin
                        t_reg <= !t_reg;
                    end
                end
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase

        // Output payload.
        if ((state_reg == ST_EMIT) && out_free)
        begin
            pair_index_reg <= idx_reg[SLOT_FLD_W-1:0];
            char_bit_reg   <= bit_reg;
            last_reg       <= is_last_pair;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pair_index = pair_index_reg;
    assign char_bit   = char_bit_reg;
    assign last       = last_reg;

    // The pair walk never runs past the latched count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg < lim_reg))
        else $error("pair index beyond count");

    // The Jacobi modulus stays odd throughout the loop.
    a_jac_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_JAC) |-> n_reg[0])
        else $error("even Jacobi modulus");

    // Residues stay reduced during the serial passes.
    a_acc_red: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_REDA) || (state_reg == ST_REDS) || (state_reg == ST_MUL))
        |-> (acc_reg < q_reg))
        else $error("residue not reduced");

    // A query is only accepted while no earlier query is still walking.
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        query_take |=> ((state_reg == ST_READ) || (state_reg == ST_IDLE)))
        else $error("query accepted mid-walk");

endmodule
